FILE: hdl/tfn_pkg.sv
// Shared widths, types and step functions for the triangle face normal block.
// Used by the interfaces, tfn_sqrt, tfn_div and triangle_face_normal_top.
package tfn_pkg;

  localparam int CW   = 21;          // vertex coordinate
  localparam int DW   = CW + 1;      // edge component
  localparam int PW   = 2 * DW;      // edge product
  localparam int XW   = PW + 1;      // cross product component
  localparam int MW   = XW - 1;      // cross product magnitude
  localparam int NW   = 30;          // normalized magnitude
  localparam int FRAC = MW - NW;     // bits dropped after left-justify
  localparam int SW   = 64;          // square sum and root datapath
  localparam int RW   = 32;          // root
  localparam int QW   = 16;          // quotient
  localparam int OW   = 16;          // output component
  localparam int DVW  = 47;          // division remainder
  localparam int UNIT_SH    = 14;    // Q1.14
  localparam int SQ_STAGES  = SW / 4;
  localparam int DIV_STAGES = QW / 2;

  localparam logic signed [OW-1:0] NEG_UNIT = -16'sd16384;

  typedef logic [2:0][MW-1:0] mag3_t;

  typedef struct packed {
    logic [2:0][NW-1:0] m;
    logic [2:0]         neg;
    logic               rej;
    logic               zero;
  } tail_t;

  typedef struct packed {
    logic [SW-1:0] x;
    logic [SW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [DVW-1:0] rem;
    logic [QW-1:0]  q;
  } dv_t;

  // One digit of the bitwise integer square root.
  function automatic sq_t isq_step(sq_t s, logic [SW-1:0] b);
    sq_t           o;
    logic [SW-1:0] t;
    t = s.res + b;
    if (s.x >= t) begin
      o.x   = s.x - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.x   = s.x;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // One quotient bit of restoring division against a shifted divisor.
  function automatic dv_t div_step(dv_t s, logic [DVW-1:0] d);
    dv_t o;
    if (s.rem >= d) begin
      o.rem = s.rem - d;
      o.q   = {s.q[QW-2:0], 1'b1};
    end else begin
      o.rem = s.rem;
      o.q   = {s.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  // Left shift of all three magnitudes by sh when the OR has sh leading zeros.
  function automatic mag3_t nrm_step(mag3_t v, int sh);
    logic [MW-1:0] o;
    mag3_t         r;
    o = v[0] | v[1] | v[2];
    r = v;
    if ((o >> (MW - sh)) == '0) begin
      r[0] = v[0] << sh;
      r[1] = v[1] << sh;
      r[2] = v[2] << sh;
    end
    return r;
  endfunction

endpackage

FILE: hdl/tfn_face_if.sv
// Face input channel: three vertex positions and depth-invalid flags.
// Depends on tfn_pkg.
interface tfn_face_if;
  logic                          valid;
  logic                          ready;
  logic signed [tfn_pkg::CW-1:0] v0_x, v0_y, v0_z;
  logic signed [tfn_pkg::CW-1:0] v1_x, v1_y, v1_z;
  logic signed [tfn_pkg::CW-1:0] v2_x, v2_y, v2_z;
  logic                          v0_z_bad, v1_z_bad, v2_z_bad;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  v0_z_bad, v1_z_bad, v2_z_bad, input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  v0_z_bad, v1_z_bad, v2_z_bad, output ready);
endinterface

FILE: hdl/tfn_normal_if.sv
// Normal output channel: Q1.14 unit normal and rejection flag.
// Depends on tfn_pkg.
interface tfn_normal_if;
  logic                          valid;
  logic                          ready;
  logic signed [tfn_pkg::OW-1:0] normal_x, normal_y, normal_z;
  logic                          face_rejected;

  modport source (output valid, normal_x, normal_y, normal_z, face_rejected, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, face_rejected, output ready);
endinterface

FILE: hdl/tfn_sqrt.sv
// Pipelined integer square root, two result bits per stage.
// Depends on tfn_pkg.
module tfn_sqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [tfn_pkg::SW-1:0] s_in,
  input  tfn_pkg::tail_t         tail_in,
  output logic                   out_valid,
  output logic [tfn_pkg::RW-1:0] root,
  output tfn_pkg::tail_t         tail_out
);
  localparam int NST = tfn_pkg::SQ_STAGES;
  localparam int SW  = tfn_pkg::SW;

  logic           vld [NST];
  tfn_pkg::sq_t   st  [NST];
  tfn_pkg::tail_t tl  [NST];
  tfn_pkg::sq_t   nxt [NST];

  for (genvar j = 0; j < NST; j++) begin : g_st
    localparam logic [SW-1:0] B0 = SW'(1) << (SW - 2 - 4 * j);
    localparam logic [SW-1:0] B1 = SW'(1) << (SW - 4 - 4 * j);
    tfn_pkg::sq_t src;
    if (j == 0) begin : g_first
      assign src = '{x: s_in, res: '0};
    end else begin : g_next
      assign src = st[j-1];
    end
    assign nxt[j] = tfn_pkg::isq_step(tfn_pkg::isq_step(src, B0), B1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NST; j++) vld[j] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int j = 1; j < NST; j++) vld[j] <= vld[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tl[0] <= tail_in;
      for (int j = 1; j < NST; j++) tl[j] <= tl[j-1];
      for (int j = 0; j < NST; j++) st[j] <= nxt[j];
    end
  end

  assign out_valid = vld[NST-1];
  assign root      = st[NST-1].res[tfn_pkg::RW-1:0];
  assign tail_out  = tl[NST-1];
endmodule

FILE: hdl/tfn_div.sv
// Three-lane pipelined restoring divider: q = (m * 2^14 + r/2) / r.
// Depends on tfn_pkg.
module tfn_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [tfn_pkg::RW-1:0]      root,
  input  tfn_pkg::tail_t              tail_in,
  output logic                        out_valid,
  output logic [2:0][tfn_pkg::QW-1:0] q,
  output tfn_pkg::tail_t              tail_out
);
  localparam int NST = tfn_pkg::DIV_STAGES;
  localparam int DVW = tfn_pkg::DVW;
  localparam int QW  = tfn_pkg::QW;

  // numerator setup stage
  logic              vp;
  tfn_pkg::dv_t [2:0] lp;
  logic [tfn_pkg::RW-1:0] rp;
  tfn_pkg::tail_t    tp;

  logic               vld [NST];
  tfn_pkg::dv_t [2:0] ln  [NST];
  tfn_pkg::dv_t [2:0] nxt [NST];
  logic [tfn_pkg::RW-1:0] rd [NST];
  tfn_pkg::tail_t     tl  [NST];

  for (genvar j = 0; j < NST; j++) begin : g_st
    localparam int K0 = QW - 1 - 2 * j;
    localparam int K1 = QW - 2 - 2 * j;
    tfn_pkg::dv_t [2:0]     src;
    logic [tfn_pkg::RW-1:0] r;
    if (j == 0) begin : g_first
      assign src = lp;
      assign r   = rp;
    end else begin : g_next
      assign src = ln[j-1];
      assign r   = rd[j-1];
    end
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign nxt[j][i] = tfn_pkg::div_step(tfn_pkg::div_step(src[i], DVW'(r) << K0),
                                           DVW'(r) << K1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
      for (int j = 0; j < NST; j++) vld[j] <= 1'b0;
    end else if (en) begin
      vp     <= in_valid;
      vld[0] <= vp;
      for (int j = 1; j < NST; j++) vld[j] <= vld[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lp[i].rem <= (DVW'(tail_in.m[i]) << tfn_pkg::UNIT_SH) + DVW'(root >> 1);
        lp[i].q   <= '0;
      end
      rp    <= root;
      tp    <= tail_in;
      rd[0] <= rp;
      tl[0] <= tp;
      for (int j = 1; j < NST; j++) begin
        rd[j] <= rd[j-1];
        tl[j] <= tl[j-1];
      end
      for (int j = 0; j < NST; j++) ln[j] <= nxt[j];
    end
  end

  assign out_valid = vld[NST-1];
  assign tail_out  = tl[NST-1];
  always_comb begin
    for (int i = 0; i < 3; i++) q[i] = ln[NST-1][i].q;
  end
endmodule

FILE: hdl/triangle_face_normal_top.sv
// Triangle face normal: top level, edge/cross/normalize front end plus root and divide.
// Depends on tfn_pkg, tfn_face_if, tfn_normal_if, tfn_sqrt and tfn_div.
//
// Usage:
//  - face channel (valid/ready) carries one triangle as three Q4.16 vertices plus
//    a depth-invalid flag per vertex; normal channel returns one item per face:
//    Q1.14 unit normal and face_rejected.
//  - A face with any depth flag set, or an edge z change above max_depth_change
//    (strictly greater), gives (0,0,-1) with face_rejected high. A face whose
//    cross product is zero gives the zero vector.
//  - max_depth_change: write via cfg_wr_en/cfg_wr_data only while idle; not enforced.
//  - Pipeline: 35 register stages from the face channel to the normal channel: 9 front
//    end stages (edges, products, cross, magnitude, three normalize stages, squares,
//    sum), 16 root stages at two bits each, a numerator setup stage plus 8 divide
//    stages at two quotient bits each, one output register.
//  - Throughput: one face per cycle. Every stage carries its own valid bit, so
//    bubbles are held too; the whole pipe advances together whenever the output
//    register is empty or being taken.
//  - Stall: while the receiver holds ready low on a full output register the
//    pipe freezes and face.ready drops; nothing is lost or repeated.
//  - Reset (rst, synchronous): clears all valid bits and restores the depth
//    limit to 6554; no clearing pass is needed.
module triangle_face_normal_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [tfn_pkg::CW-1:0] cfg_wr_data,
  tfn_face_if.sink               face,
  tfn_normal_if.source           result
);
  localparam int DW = tfn_pkg::DW;
  localparam int PW = tfn_pkg::PW;
  localparam int XW = tfn_pkg::XW;
  localparam int MW = tfn_pkg::MW;
  localparam int NW = tfn_pkg::NW;
  localparam int SW = tfn_pkg::SW;

  logic [tfn_pkg::CW-1:0] max_depth_change;
  logic en;

  // the whole pipe moves when the output register can take an item
  assign en         = !result.valid || result.ready;
  assign face.ready = en;

  always_ff @(posedge clk) begin
    if (rst) max_depth_change <= tfn_pkg::CW'(6554);
    else if (cfg_wr_en) max_depth_change <= cfg_wr_data;
  end

  // stage 1: edges and depth check
  logic signed [DW-1:0] ax_c, ay_c, az_c, bx_c, by_c, bz_c;
  logic [DW-1:0]        az_abs, bz_abs;
  logic                 rej_c;

  assign ax_c = DW'(face.v1_x) - DW'(face.v0_x);
  assign ay_c = DW'(face.v1_y) - DW'(face.v0_y);
  assign az_c = DW'(face.v1_z) - DW'(face.v0_z);
  assign bx_c = DW'(face.v2_x) - DW'(face.v0_x);
  assign by_c = DW'(face.v2_y) - DW'(face.v0_y);
  assign bz_c = DW'(face.v2_z) - DW'(face.v0_z);
  assign az_abs = az_c[DW-1] ? DW'(-az_c) : DW'(az_c);
  assign bz_abs = bz_c[DW-1] ? DW'(-bz_c) : DW'(bz_c);
  assign rej_c = face.v0_z_bad || face.v1_z_bad || face.v2_z_bad
              || (az_abs > DW'(max_depth_change)) || (bz_abs > DW'(max_depth_change));

  logic                 v1;
  logic signed [DW-1:0] ax, ay, az, bx, by, bz;
  logic                 rej1;

  // stage 2: products
  logic                 v2;
  logic signed [PW-1:0] p [6];
  logic                 rej2;

  // stage 3: cross product
  logic                 v3;
  logic signed [XW-1:0] c [3];
  logic                 rej3;

  // stage 4: magnitudes and signs
  logic                 v4;
  tfn_pkg::mag3_t       mag4;
  logic [2:0]           neg4;
  logic                 rej4;

  // stages 5..7: left-justify the largest magnitude, two shift steps each
  logic                 vn  [3];
  tfn_pkg::mag3_t       nm  [3];
  logic [2:0]           ng  [3];
  logic                 rjn [3];
  logic                 zrn [3];
  tfn_pkg::mag3_t       nm_next [3];

  assign nm_next[0] = tfn_pkg::nrm_step(tfn_pkg::nrm_step(mag4, 32), 16);
  assign nm_next[1] = tfn_pkg::nrm_step(tfn_pkg::nrm_step(nm[0], 8), 4);
  assign nm_next[2] = tfn_pkg::nrm_step(tfn_pkg::nrm_step(nm[1], 2), 1);

  // stage 8: squares
  logic                 v8;
  logic [2*NW-1:0]      sq [3];
  tfn_pkg::tail_t       t8;
  logic [2:0][NW-1:0]   m_c;

  always_comb begin
    for (int i = 0; i < 3; i++) m_c[i] = nm[2][i][MW-1:tfn_pkg::FRAC];
  end

  // stage 9: sum of squares
  logic                 v9;
  logic [SW-1:0]        sum9;
  tfn_pkg::tail_t       t9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      for (int j = 0; j < 3; j++) vn[j] <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (en) begin
      v1    <= face.valid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      vn[0] <= v4;
      vn[1] <= vn[0];
      vn[2] <= vn[1];
      v8    <= vn[2];
      v9    <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= ax_c; ay <= ay_c; az <= az_c;
      bx <= bx_c; by <= by_c; bz <= bz_c;
      rej1 <= rej_c;

      p[0] <= PW'(ay) * PW'(bz);
      p[1] <= PW'(az) * PW'(by);
      p[2] <= PW'(az) * PW'(bx);
      p[3] <= PW'(ax) * PW'(bz);
      p[4] <= PW'(ax) * PW'(by);
      p[5] <= PW'(ay) * PW'(bx);
      rej2 <= rej1;

      for (int i = 0; i < 3; i++) c[i] <= XW'(p[2*i]) - XW'(p[2*i+1]);
      rej3 <= rej2;

      for (int i = 0; i < 3; i++) begin
        mag4[i] <= c[i][XW-1] ? MW'(-c[i]) : MW'(c[i]);
        neg4[i] <= c[i][XW-1];
      end
      rej4 <= rej3;

      nm[0]  <= nm_next[0];
      ng[0]  <= neg4;
      rjn[0] <= rej4;
      zrn[0] <= (mag4[0] | mag4[1] | mag4[2]) == '0;
      for (int j = 1; j < 3; j++) begin
        nm[j]  <= nm_next[j];
        ng[j]  <= ng[j-1];
        rjn[j] <= rjn[j-1];
        zrn[j] <= zrn[j-1];
      end

      for (int i = 0; i < 3; i++) sq[i] <= (2*NW)'(m_c[i]) * (2*NW)'(m_c[i]);
      t8.m    <= m_c;
      t8.neg  <= ng[2];
      t8.rej  <= rjn[2];
      t8.zero <= zrn[2];

      sum9 <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      t9   <= t8;
    end
  end

  // root and divide
  logic                   vs;
  logic [tfn_pkg::RW-1:0] root;
  tfn_pkg::tail_t         ts;

  tfn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v9),
    .s_in      (sum9),
    .tail_in   (t9),
    .out_valid (vs),
    .root      (root),
    .tail_out  (ts)
  );

  logic                        vd;
  logic [2:0][tfn_pkg::QW-1:0] q;
  tfn_pkg::tail_t              td;

  tfn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vs),
    .root      (root),
    .tail_in   (ts),
    .out_valid (vd),
    .q         (q),
    .tail_out  (td)
  );

  // output register: sign, sentinel for rejected faces, zero for degenerate ones
  logic signed [tfn_pkg::OW-1:0] comp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (td.rej || td.zero) comp[i] = '0;
      else if (td.neg[i]) comp[i] = tfn_pkg::OW'(-q[i]);
      else comp[i] = tfn_pkg::OW'(q[i]);
    end
    if (td.rej) comp[2] = tfn_pkg::NEG_UNIT;
  end

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (en) result.valid <= vd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.normal_x      <= comp[0];
      result.normal_y      <= comp[1];
      result.normal_z      <= comp[2];
      result.face_rejected <= td.rej;
    end
  end

`ifndef NO_ASSERTIONS
  a_sentinel: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.face_rejected |->
      result.normal_x == 16'sd0 && result.normal_y == 16'sd0 &&
      result.normal_z == tfn_pkg::NEG_UNIT)
    else $error("rejected face without sentinel normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.face_rejected |->
      result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384 &&
      result.normal_y <= 16'sd16384 && result.normal_y >= -16'sd16384 &&
      result.normal_z <= 16'sd16384 && result.normal_z >= -16'sd16384)
    else $error("normal component out of unit range");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
`endif
endmodule

FILE: verif/triangle_face_normal_checker.sv
// Checker for triangle_face_normal_top: watches the face and normal channels,
// predicts each normal and compares it. Depends on tfn_pkg and both interfaces.
`timescale 1ns / 100ps
module triangle_face_normal_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [tfn_pkg::CW-1:0] cfg_wr_data,
  tfn_face_if.sink               face_mon,
  tfn_normal_if.sink             norm_mon,
  output int                     fail_count,
  output int                     pending_normals
);
  typedef struct {
    logic signed [tfn_pkg::OW-1:0] nx, ny, nz;
    logic                          rej;
  } normal_t;

  normal_t     expected_normals[$];
  logic [20:0] depth_limit;

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(longint p[9], logic bad);
    normal_t         n;
    longint          ax, ay, az, bx, by, bz;
    longint          c[3];
    longint unsigned m[3], big, s, r, q;
    ax = p[3] - p[0]; ay = p[4] - p[1]; az = p[5] - p[2];
    bx = p[6] - p[0]; by = p[7] - p[1]; bz = p[8] - p[2];
    n.nx = 0; n.ny = 0; n.nz = 0; n.rej = 0;
    if (bad || mag(az) > depth_limit || mag(bz) > depth_limit) begin
      n.nz = tfn_pkg::NEG_UNIT;
      n.rej = 1;
      return n;
    end
    c[0] = ay * bz - az * by;
    c[1] = az * bx - ax * bz;
    c[2] = ax * by - ay * bx;
    for (int i = 0; i < 3; i++) m[i] = mag(c[i]);
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    if (big == 0) return n;
    while (big >= (64'd1 << 30)) begin
      big >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (big < (64'd1 << 29)) begin
      big <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = int_root(s);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + (r >> 1)) / r;
      if (c[i] < 0) q = -q;
      if (i == 0) n.nx = q[15:0];
      else if (i == 1) n.ny = q[15:0];
      else n.nz = q[15:0];
    end
    return n;
  endfunction

  assign pending_normals = expected_normals.size();

  always @(posedge clk) begin
    longint  p[9];
    normal_t e;
    if (rst) begin
      depth_limit <= 21'd6554;
      expected_normals.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) depth_limit <= cfg_wr_data;
      if (face_mon.valid && face_mon.ready) begin
        p = '{face_mon.v0_x, face_mon.v0_y, face_mon.v0_z,
              face_mon.v1_x, face_mon.v1_y, face_mon.v1_z,
              face_mon.v2_x, face_mon.v2_y, face_mon.v2_z};
        expected_normals.push_back(face_normal(p,
          face_mon.v0_z_bad | face_mon.v1_z_bad | face_mon.v2_z_bad));
      end
      if (norm_mon.valid && norm_mon.ready) begin
        if (expected_normals.size() == 0) begin
          $error("normal item with no face pending");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_normals.pop_front();
          if (norm_mon.normal_x !== e.nx || norm_mon.normal_y !== e.ny ||
              norm_mon.normal_z !== e.nz || norm_mon.face_rejected !== e.rej) begin
            if (norm_mon.normal_x !== e.nx)
              $error("normal_x expected %0d got %0d", e.nx, norm_mon.normal_x);
            if (norm_mon.normal_y !== e.ny)
              $error("normal_y expected %0d got %0d", e.ny, norm_mon.normal_y);
            if (norm_mon.normal_z !== e.nz)
              $error("normal_z expected %0d got %0d", e.nz, norm_mon.normal_z);
            if (norm_mon.face_rejected !== e.rej)
              $error("face_rejected expected %0d got %0d", e.rej,
                     norm_mon.face_rejected);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: verif/triangle_face_normal_top_test.sv
// Testbench top for triangle_face_normal_top: drives faces and depth limits,
// stalls the normal channel, gives the verdict. Depends on the checker module.
`timescale 1ns / 100ps
module triangle_face_normal_top_test;
  localparam int LATENCY = 35;
  localparam int CW      = tfn_pkg::CW;

  logic            clk = 0;
  logic            rst = 1;
  logic            cfg_wr_en = 0;
  logic [CW-1:0]   cfg_wr_data = '0;
  int              fail_count, pending_normals;
  bit              hold_off = 0;   // long receiver stall requested by stimulus
  bit              hold_done = 0;

  tfn_face_if   face();
  tfn_normal_if result();

  triangle_face_normal_top uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .face(face.sink), .result(result.source)
  );

  triangle_face_normal_checker chk (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .face_mon(face.sink), .norm_mon(result.sink),
    .fail_count(fail_count), .pending_normals(pending_normals)
  );

  always #4 clk = ~clk;

  // Receiver: mode switches between always ready, random stalls and long
  // stall bursts. A hold-off request forces ready low once, until its counter runs out.
  always @(posedge clk) begin
    int mode, cnt;
    if (rst) begin
      result.ready <= 0;
      mode = 0;
      cnt = 0;
    end else if (hold_off && !hold_done) begin
      result.ready <= 0;
      cnt++;
      if (cnt > 120) begin
        hold_done = 1;
        cnt = 0;
      end
    end else begin
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: result.ready <= 1;
        1: result.ready <= ($urandom_range(0, 3) != 0);
        default: result.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Random coordinate, biased toward extremes and small values.
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 21'h100000;
      1: return 21'h0FFFFF;
      2: return CW'($urandom_range(0, 15));
      3: return CW'(-$urandom_range(0, 15));
      default: return CW'($urandom);
    endcase
  endfunction

  // Drives one face with its depth flags and waits until face.ready takes it.
  task automatic send_face(logic [CW-1:0] p[9], logic [2:0] bad);
    face.valid    <= 1;
    face.v0_x <= p[0]; face.v0_y <= p[1]; face.v0_z <= p[2];
    face.v1_x <= p[3]; face.v1_y <= p[4]; face.v1_z <= p[5];
    face.v2_x <= p[6]; face.v2_y <= p[7]; face.v2_z <= p[8];
    {face.v2_z_bad, face.v1_z_bad, face.v0_z_bad} <= bad;
    do @(posedge clk); while (!face.ready);
  endtask

  task automatic idle_gap(int n);
    face.valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    face.valid <= 0;
    while (pending_normals != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_limit(logic [CW-1:0] v);
    drain();
    cfg_wr_en   <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_face(int near);
    logic [CW-1:0] p[9];
    logic [2:0]    bad;
    for (int i = 0; i < 9; i++) p[i] = rand_coord();
    if (near != 0) begin
      // z near v0 so the edge check passes or sits at the limit
      p[5] = CW'(p[2] + $urandom_range(0, 2 * near) - near);
      p[8] = CW'(p[2] + $urandom_range(0, 2 * near) - near);
    end
    bad = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
    send_face(p, bad);
  endtask

  initial begin
    logic [CW-1:0] p[9];
    int limits[5];
    face.valid = 0;
    {face.v0_x, face.v0_y, face.v0_z, face.v1_x, face.v1_y, face.v1_z} = '0;
    {face.v2_x, face.v2_y, face.v2_z} = '0;
    {face.v0_z_bad, face.v1_z_bad, face.v2_z_bad} = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero face, extremes, flags, limit equality, degenerate line.
    p = '{default: 0};
    send_face(p, 3'b000);
    send_face(p, 3'b001);
    send_face(p, 3'b010);
    send_face(p, 3'b100);
    p = '{0, 0, 0, 21'h10000, 0, 0, 0, 21'h10000, 0};
    send_face(p, 3'b000);
    p = '{0, 0, 0, 21'h10000, 0, 21'd6554, 0, 21'h10000, -21'sd6554};
    send_face(p, 3'b000);
    p[5] = 21'd6555;
    send_face(p, 3'b000);
    p = '{0, 0, 0, 21'h1, 21'h1, 0, 21'h2, 21'h2, 0};
    send_face(p, 3'b000);
    p = '{21'h100000, 21'h100000, 0, 21'h0FFFFF, 21'h100000, 0,
          21'h100000, 21'h0FFFFF, 0};
    send_face(p, 3'b000);
    p = '{21'h0FFFFF, 21'h100000, 21'h0FFFFF, 21'h100000, 21'h0FFFFF,
          21'h100000, 21'h0FFFFF, 21'h0FFFFF, 21'h100000};
    send_face(p, 3'b000);
    set_limit(21'h1FFFFF);
    send_face(p, 3'b000);
    send_face(p, 3'b111);
    p = '{0, 0, 0, 21'h1, 0, 21'h1, 0, 21'h1, 21'h1};
    set_limit(CW'(0));
    send_face(p, 3'b000);
    p[5] = 0; p[8] = 0;
    send_face(p, 3'b000);

    // Random phases over several limits, including both extremes.
    limits = '{0, 6554, 21'h1FFFFF, 100000, 1};
    for (int ph = 0; ph < 5; ph++) begin
      set_limit(CW'(limits[ph]));
      for (int k = 0; k < 140; k++) begin
        if (ph == 1 && k == 40) hold_off = 1;  // long receiver stall
        if (ph == 3 && k == 70) drain();        // sender waits for all results
        if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 6));
        random_face((limits[ph] > 0 && $urandom_range(0, 3) != 0) ?
                    limits[ph] : 0);
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
